// ===== hw/rtl/watchdog_control_register_protect_macros.svh =====
// assertion macros for the watchdog control register protection block
`ifndef WATCHDOG_CONTROL_REGISTER_PROTECT_MACROS_SVH
`define WATCHDOG_CONTROL_REGISTER_PROTECT_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define WDCRP_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define WDCRP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hw/rtl/wdcrp_pkg.sv =====
// shared types and constants for the watchdog control register protection block
`timescale 1ns / 1ps

package wdcrp_pkg;

	localparam int unsigned AUTOCLEAR_TICKS_DEF = 4;

	// control register bit positions
	localparam int unsigned BIT_WDE  = 3;
	localparam int unsigned BIT_WDCE = 4;
	localparam int unsigned BIT_WDIE = 6;
	localparam int unsigned BIT_WDIF = 7;

	localparam logic [7:0] PRESCALE_MASK = 8'h27;
	localparam logic [7:0] CTRL_FUSE_RESET = 8'h08;
	localparam logic [7:0] CTRL_RESET = 8'h00;

	typedef enum logic [2:0] {
		MODE_WRITE     = 3'd0,
		MODE_TICK      = 3'd1,
		MODE_DEV_RESET = 3'd2,
		MODE_FLAG_CLR  = 3'd3,
		MODE_FLAG_SET  = 3'd4
	} mode_t;

	typedef enum logic [1:0] {
		REF_NONE      = 2'd0,
		REF_FUSE      = 2'd1,
		REF_FLAG_LOCK = 2'd2,
		REF_CE_CLEAR  = 2'd3
	} en_ref_t;

endpackage

// ===== hw/rtl/watchdog_control_register_protect.sv =====
// protected watchdog control register with timed change-enable window
// results: the result of an accepted transaction is registered and valid in the following cycle
// throughput: one transaction per cycle while out_ready holds; the register update is a single pass of gates
// input ready follows the output register (free, or being taken in the same cycle)
// reset: control register, reset-flag lock, pending clears and fuse lock clear to zero
`timescale 1ns / 1ps

`include "watchdog_control_register_protect_macros.svh"

module watchdog_control_register_protect #(
	parameter int unsigned AUTOCLEAR_TICKS = wdcrp_pkg::AUTOCLEAR_TICKS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_write_en,
	input  logic       cfg_write_data,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [2:0] mode,
	input  logic [7:0] write_data,
	input  logic       reset_by_watchdog,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] control_value,
	output logic       flag_clear_pulse,
	output logic       prescale_refused,
	output logic [1:0] enable_clear_refused,
	output logic       change_enable_refused,
	output logic       irq_enable_refused,
	output logic       auto_cleared
);

	localparam int unsigned PEND_TOP = AUTOCLEAR_TICKS - 1;

	logic                       fuse_q;
	logic [7:0]                 ctrl_q, ctrl_d;
	logic                       flag_lock_q, flag_lock_d;
	logic [AUTOCLEAR_TICKS-1:0] pend_q, pend_d;

	logic                pulse_d, pre_ref_d, ce_ref_d, ie_ref_d, auto_clr_d;
	wdcrp_pkg::en_ref_t  en_ref_d;

	logic                out_valid_q;
	logic [7:0]          res_ctrl_q;
	logic                res_pulse_q, res_pre_ref_q, res_ce_ref_q, res_ie_ref_q, res_auto_q;
	wdcrp_pkg::en_ref_t  res_en_ref_q;

	logic accept;

	assign in_ready = !out_valid_q || out_ready;
	assign accept   = in_valid && in_ready;

	always_comb begin
		ctrl_d      = ctrl_q;
		flag_lock_d = flag_lock_q;
		pend_d      = pend_q;
		pulse_d     = 1'b0;
		pre_ref_d   = 1'b0;
		en_ref_d    = wdcrp_pkg::REF_NONE;
		ce_ref_d    = 1'b0;
		ie_ref_d    = 1'b0;
		auto_clr_d  = 1'b0;
		unique case (mode)
			wdcrp_pkg::MODE_WRITE: begin
				// prescaler changes only inside the change-enable window
				if ((write_data & wdcrp_pkg::PRESCALE_MASK) !=
						(ctrl_q & wdcrp_pkg::PRESCALE_MASK)) begin
					if (!ctrl_q[wdcrp_pkg::BIT_WDCE]) begin
						pre_ref_d = 1'b1;
					end else begin
						ctrl_d = (ctrl_d & ~wdcrp_pkg::PRESCALE_MASK) |
							(write_data & wdcrp_pkg::PRESCALE_MASK);
					end
				end
				if (!write_data[wdcrp_pkg::BIT_WDE] && ctrl_d[wdcrp_pkg::BIT_WDE]) begin
					if (fuse_q) begin
						en_ref_d = wdcrp_pkg::REF_FUSE;
					end else if (flag_lock_q) begin
						en_ref_d = wdcrp_pkg::REF_FLAG_LOCK;
					end else if (!ctrl_q[wdcrp_pkg::BIT_WDCE]) begin
						en_ref_d = wdcrp_pkg::REF_CE_CLEAR;
					end else begin
						ctrl_d[wdcrp_pkg::BIT_WDE] = 1'b0;
					end
				end else if (!fuse_q) begin
					ctrl_d[wdcrp_pkg::BIT_WDE] = write_data[wdcrp_pkg::BIT_WDE];
				end
				// opening the window needs reset enable in the same write
				if (write_data[wdcrp_pkg::BIT_WDCE] && !ctrl_d[wdcrp_pkg::BIT_WDCE]) begin
					if (write_data[wdcrp_pkg::BIT_WDE]) begin
						ctrl_d[wdcrp_pkg::BIT_WDCE] = 1'b1;
						pend_d[PEND_TOP]            = 1'b1;
					end else begin
						ce_ref_d = 1'b1;
					end
				end else begin
					ctrl_d[wdcrp_pkg::BIT_WDCE] = write_data[wdcrp_pkg::BIT_WDCE];
				end
				if (write_data[wdcrp_pkg::BIT_WDIE] && fuse_q) begin
					ie_ref_d = 1'b1;
				end else if (!fuse_q) begin
					ctrl_d[wdcrp_pkg::BIT_WDIE] = write_data[wdcrp_pkg::BIT_WDIE];
				end
				// write one to clear the interrupt flag
				if (write_data[wdcrp_pkg::BIT_WDIF]) begin
					ctrl_d[wdcrp_pkg::BIT_WDIF] = 1'b0;
					pulse_d                     = 1'b1;
				end
			end
			wdcrp_pkg::MODE_TICK: begin
				if (pend_q[0]) begin
					auto_clr_d                  = ctrl_q[wdcrp_pkg::BIT_WDCE];
					ctrl_d[wdcrp_pkg::BIT_WDCE] = 1'b0;
				end
				pend_d = pend_q >> 1;
			end
			wdcrp_pkg::MODE_DEV_RESET: begin
				ctrl_d      = fuse_q ? wdcrp_pkg::CTRL_FUSE_RESET : wdcrp_pkg::CTRL_RESET;
				flag_lock_d = 1'b0;
				pend_d      = '0;
				if (reset_by_watchdog) begin
					flag_lock_d                = 1'b1;
					ctrl_d[wdcrp_pkg::BIT_WDE] = 1'b1;
				end
			end
			wdcrp_pkg::MODE_FLAG_CLR: begin
				flag_lock_d = 1'b0;
			end
			wdcrp_pkg::MODE_FLAG_SET: begin
				flag_lock_d                = 1'b1;
				ctrl_d[wdcrp_pkg::BIT_WDE] = 1'b1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fuse_q      <= 1'b0;
			ctrl_q      <= '0;
			flag_lock_q <= 1'b0;
			pend_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_write_en) begin
				fuse_q <= cfg_write_data;
			end
			if (accept) begin
				ctrl_q      <= ctrl_d;
				flag_lock_q <= flag_lock_d;
				pend_q      <= pend_d;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// result payload, no reset needed
	always_ff @(posedge clk) begin
		if (accept) begin
			res_ctrl_q    <= ctrl_d;
			res_pulse_q   <= pulse_d;
			res_pre_ref_q <= pre_ref_d;
			res_en_ref_q  <= en_ref_d;
			res_ce_ref_q  <= ce_ref_d;
			res_ie_ref_q  <= ie_ref_d;
			res_auto_q    <= auto_clr_d;
		end
	end

	assign out_valid             = out_valid_q;
	assign control_value         = res_ctrl_q;
	assign flag_clear_pulse      = res_pulse_q;
	assign prescale_refused      = res_pre_ref_q;
	assign enable_clear_refused  = res_en_ref_q;
	assign change_enable_refused = res_ce_ref_q;
	assign irq_enable_refused    = res_ie_ref_q;
	assign auto_cleared          = res_auto_q;

	`WDCRP_ASSERT_IMPL(a_ce_has_pending_clear, clk, arst_n, ctrl_q[wdcrp_pkg::BIT_WDCE], pend_q != '0, "change enable set with no clear scheduled")
	`WDCRP_ASSERT_IMPL(a_lock_keeps_wde, clk, arst_n, flag_lock_q, ctrl_q[wdcrp_pkg::BIT_WDE], "reset-flag lock held with reset enable clear")
	`WDCRP_ASSERT_NEXT(a_dev_reset_state, clk, arst_n, accept && mode == wdcrp_pkg::MODE_DEV_RESET, (flag_lock_q == $past(reset_by_watchdog)) && (pend_q == '0), "device reset left stale lock or pending clears")
	`WDCRP_ASSERT_NEXT(a_accept_gives_result, clk, arst_n, accept, out_valid_q && (res_ctrl_q == ctrl_q), "transaction did not load a matching result")

endmodule
